// File: rtl/signed_int_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text converter
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SIDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sida assertion failed");
// Next-cycle implication
`define SIDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sida assertion failed");
`else
`define SIDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SIDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/sida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_pkg
// Shared widths, character codes and control types of the converter.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CNT_W      = 5;

  localparam logic [CNT_W-1:0]  CNT_LAST    = 5'd31;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  typedef struct packed {
    logic             load;       // capture magnitude and sign
    logic             shift;      // one double-dabble step
    logic             out_load;   // write the output character register
    logic             out_sign;   // character is the minus sign
    logic             out_last;   // character closes the number
    logic [IDX_W-1:0] digit_idx;  // BCD digit to emit
  } cmd_t;

  typedef struct packed {
    logic             neg;        // value was negative
    logic [IDX_W-1:0] lead_idx;   // highest nonzero digit, zero if none
  } status_t;

endpackage

// File: rtl/sida_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_in_if / sida_out_if
// Valid/ready channels carrying the integer in and the characters out.
// ----------------------------------------------------------------------------
interface sida_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sida_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sida_out_if;
  logic                        valid;
  logic                        ready;
  logic [sida_pkg::CHAR_W-1:0] char_code;
  logic                        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit signed integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Each accepted integer produces its decimal text one character per transfer,
// most significant first: a '-' for negative values, then the digits without
// leading zeros (zero gives a single '0'); last_char marks the final digit.
// The most negative value prints correctly as -2147483648. One integer is
// processed at a time: after acceptance the shift-add-3 converter runs 32
// steps, then a sign state emits the '-' if needed and a digit state emits the
// digits one by one; both hold while the output register is still full. The
// output character sits in a register, so the next integer is accepted while
// the last character of the previous one still waits for its transfer.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii (
  input  logic              clk_i,
  input  logic              rst_ni,
  sida_in_if.sink           in_i,
  sida_out_if.source        out_o
);

  sida_pkg::cmd_t    cmd;
  sida_pkg::status_t status;
  logic              char_legal;

  // Sequencer: owns the handshakes and the step counter
  sida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Converter and output character register
  sida_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .value_i     (in_i.value),
    .status_o    (status),
    .char_code_o (out_o.char_code),
    .last_char_o (out_o.last_char)
  );

  // A minus sign never closes the text; anything else must be a digit
  assign char_legal =
    (out_o.char_code == sida_pkg::ASCII_MINUS && !out_o.last_char) ||
    (out_o.char_code >= sida_pkg::ASCII_ZERO &&
     out_o.char_code <= sida_pkg::ASCII_NINE);

  // Hold off new integers once one is taken
  `SIDA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  // Never accept while the converter is stepping
  `SIDA_ASSERT_IMP(a_no_accept_in_conv, clk_i, rst_ni, cmd.shift, !in_i.ready)
  // Only a minus sign (never last) or a digit leaves the block
  `SIDA_ASSERT_IMP(a_char_legal, clk_i, rst_ni, out_o.valid, char_legal)

endmodule

// File: rtl/sida_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_datapath
// Shift-add-3 binary to BCD converter and the output character register.
// ----------------------------------------------------------------------------
module sida_datapath (
  input  logic                                clk_i,
  input  sida_pkg::cmd_t                      cmd_i,
  input  logic signed [sida_pkg::VALUE_W-1:0] value_i,
  output sida_pkg::status_t                   status_o,
  output logic [sida_pkg::CHAR_W-1:0]         char_code_o,
  output logic                                last_char_o
);

  logic [sida_pkg::VALUE_W-1:0] bin_q, bin_d;
  logic [sida_pkg::BCD_W-1:0]   bcd_q, bcd_d, bcd_adj;
  logic                         neg_q, neg_d;
  logic [sida_pkg::CHAR_W-1:0]  char_q, char_d;
  logic                         last_q, last_d;
  logic [sida_pkg::IDX_W-1:0]   lead;
  logic [sida_pkg::DIGIT_W-1:0] digit_sel;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
      if (bcd_q[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] >= 4'd5) begin
        bcd_adj[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
          bcd_q[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
          bcd_q[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W];
      end
    end
  end

  // Highest nonzero digit; zero leaves digit 0
  always_comb begin
    lead = '0;
    for (int i = 1; i < sida_pkg::NUM_DIGITS; i++) begin
      if (bcd_q[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] != '0) begin
        lead = sida_pkg::IDX_W'(i);
      end
    end
  end

  assign digit_sel = bcd_q[{cmd_i.digit_idx, 2'b00} +: sida_pkg::DIGIT_W];

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.load) begin
      neg_d = value_i[sida_pkg::VALUE_W-1];
      bin_d = value_i[sida_pkg::VALUE_W-1] ? (~value_i + 1'b1) : value_i;
      bcd_d = '0;
    end else if (cmd_i.shift) begin
      bcd_d = {bcd_adj[sida_pkg::BCD_W-2:0], bin_q[sida_pkg::VALUE_W-1]};
      bin_d = {bin_q[sida_pkg::VALUE_W-2:0], 1'b0};
    end
    if (cmd_i.out_load) begin
      char_d = cmd_i.out_sign ? sida_pkg::ASCII_MINUS
                              : sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(digit_sel);
      last_d = cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.neg      = neg_q;
  assign status_o.lead_idx = lead;
  assign char_code_o       = char_q;
  assign last_char_o       = last_q;

endmodule

// File: rtl/sida_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_ctrl
// Sequencer: accept, run 32 conversion steps, emit sign and digits.
// ----------------------------------------------------------------------------
module sida_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sida_pkg::status_t status_i,
  output sida_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  state_e                     state_q;
  logic [sida_pkg::CNT_W-1:0] cnt_q;
  logic [sida_pkg::IDX_W-1:0] idx_q;
  logic                       out_valid_q;
  logic                       can_load;

  // Output slot is free when empty or drained this cycle
  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.digit_idx = idx_q;
    in_ready_o      = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE:   cmd_o.load  = in_valid_i;
      ST_CONV:   cmd_o.shift = 1'b1;
      ST_SIGN: begin
        if (status_i.neg && can_load) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sign = 1'b1;
        end
      end
      ST_DIGITS: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (idx_q == '0);
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CONV;
            cnt_q   <= '0;
          end
        end
        ST_CONV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == sida_pkg::CNT_LAST) begin
            state_q <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          if (!status_i.neg || can_load) begin
            idx_q   <= status_i.lead_idx;
            state_q <= ST_DIGITS;
          end
        end
        ST_DIGITS: begin
          if (can_load) begin
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
